// ----- src/bvl_pkg.sv -----
// ----------------------------------------------------------------------------
// bvl_pkg: shared definitions for the bounded value list
// Sizes, operation and status codes, controller states, and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bvl_pkg;

    localparam int DEPTH    = 8;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 31;
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_STEP,
        S_FRONT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    init_scan;
        logic    rd;
        logic    step;
        logic    front;
        logic    append;
        logic    finish;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            val_zero;
        logic            nval_zero;
        logic            full;
        logic            empty;
        logic            idx_out;
        logic            scan_last;
        logic            out_busy;
    } dp_stat_t;

endpackage

// ----- src/bvl_datapath.sv -----
// ----------------------------------------------------------------------------
// bvl_datapath: entry storage, scan pointers, count and result register
// Holds the entry memory with a registered read port, the request operands,
// the scan and compaction pointers, and the output register of the result.
// ----------------------------------------------------------------------------
module bvl_datapath
    import bvl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [VAL_W-1:0]    s_value,
    input  logic [VAL_W-1:0]    s_new_value,
    input  logic [INDEX_W-1:0]  s_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [CNT_W-1:0]    m_count,
    output logic [VAL_W-1:0]    m_read_value
);

    logic [VAL_W-1:0]    mem [DEPTH];
    logic [VAL_W-1:0]    rdata_reg;

    logic [OP_W-1:0]     op_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [VAL_W-1:0]    nval_reg;
    logic [INDEX_W-1:0]  idx_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    kept_reg, kept_next;
    logic [VAL_W-1:0]    rval_reg, rval_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [VAL_W-1:0]    out_rval_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic                keep;

    assign keep = (rdata_reg != val_reg);

    // Insert shifts from the top down, so it reads one below the pointer.
    always_comb begin
        priority case (op_reg)
            OP_INSERT: rd_addr = ADDR_W'(ptr_reg - CNT_W'(1));
            OP_READ:   rd_addr = ADDR_W'(idx_reg);
            default:   rd_addr = ptr_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = ptr_reg[ADDR_W-1:0];
        wr_data    = rdata_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        kept_next  = kept_reg;
        rval_next  = rval_reg;

        if (cmd.load) begin
            rval_next = '0;
        end
        if (cmd.init_scan) begin
            ptr_next  = (op_reg == OP_INSERT) ? count_reg : '0;
            kept_next = '0;
        end
        if (cmd.append) begin
            wr_en      = 1'b1;
            wr_addr    = count_reg[ADDR_W-1:0];
            wr_data    = val_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.front) begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = val_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.step) begin
            priority case (op_reg)
                OP_INSERT: begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                OP_DELETE: begin
                    // Survivors are written back at the compaction pointer.
                    if (keep) begin
                        wr_en     = 1'b1;
                        wr_addr   = kept_reg[ADDR_W-1:0];
                        kept_next = kept_reg + CNT_W'(1);
                    end
                    ptr_next = ptr_reg + CNT_W'(1);
                    if (stat.scan_last) begin
                        count_next = kept_next;
                    end
                end
                OP_REPLACE: begin
                    if (!keep) begin
                        wr_en   = 1'b1;
                        wr_data = nval_reg;
                    end
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                OP_READ: begin
                    rval_next = rdata_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        stat.op        = op_reg;
        stat.val_zero  = (val_reg == '0);
        stat.nval_zero = (nval_reg == '0);
        stat.full      = (count_reg == CNT_W'(DEPTH));
        stat.empty     = (count_reg == '0);
        stat.idx_out   = (CNT_W'(idx_reg) >= count_reg);
        stat.scan_last = (op_reg == OP_INSERT) ? (ptr_reg == CNT_W'(1))
                                               : (ptr_reg + CNT_W'(1) == count_reg);
        stat.out_busy  = out_valid_reg && !m_ready;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            val_reg  <= s_value;
            nval_reg <= s_new_value;
            idx_reg  <= s_index;
        end
        rval_reg <= rval_next;
        if (cmd.finish) begin
            out_status_reg <= cmd.status;
            out_count_reg  <= count_reg;
            out_rval_reg   <= rval_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_count      = out_count_reg;
    assign m_read_value = out_rval_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("live count exceeds list depth");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(out_valid_reg && !m_ready))
        else $error("result loaded over a pending result");

    a_grow_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.append || cmd.front) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count by one");

    a_rval_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> m_read_value == '0)
        else $error("nonzero read value on a refused request");

endmodule

// ----- src/bvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bvl_ctrl: sequencing controller of the bounded value list
// Checks each request, walks the list one entry per read and step pair,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module bvl_ctrl
    import bvl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                st_next    = ST_OK;
                state_next = S_FINISH;
                priority case (stat.op)
                    OP_INSERT, OP_APPEND: begin
                        if (stat.val_zero) begin
                            st_next = ST_ZERO;
                        end else if (stat.full) begin
                            st_next = ST_FULL;
                        end else if (stat.op == OP_INSERT) begin
                            state_next = stat.empty ? S_FRONT : S_READ;
                        end
                    end
                    OP_DELETE: begin
                        if (!stat.empty) begin
                            state_next = S_READ;
                        end
                    end
                    OP_REPLACE: begin
                        if (stat.nval_zero) begin
                            st_next = ST_ZERO;
                        end else if (!stat.empty) begin
                            state_next = S_READ;
                        end
                    end
                    OP_READ: begin
                        if (stat.idx_out) begin
                            st_next = ST_RANGE;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                state_next = S_STEP;
            end
            S_STEP: begin
                if (stat.op == OP_READ) begin
                    state_next = S_FINISH;
                end else if (stat.scan_last) begin
                    state_next = (stat.op == OP_INSERT) ? S_FRONT : S_FINISH;
                end else begin
                    state_next = S_READ;
                end
            end
            S_FRONT: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = st_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_CHECK: begin
                cmd.init_scan = 1'b1;
                cmd.append    = (stat.op == OP_APPEND) && !stat.val_zero && !stat.full;
            end
            S_READ: begin
                cmd.rd = 1'b1;
            end
            S_STEP: begin
                cmd.step = 1'b1;
            end
            S_FRONT: begin
                cmd.front = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = !stat.out_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

// ----- src/bounded_value_list.sv -----
// ----------------------------------------------------------------------------
// bounded_value_list: ordered list of up to DEPTH positive values
// Each request carries insert-at-front, append, delete-by-value,
// replace-by-value or read-at-index and yields one result with a status,
// the live count after the operation and, for a read, the entry.
//
// Usage:
//   The request channel (s_valid/s_ready) carries s_operation, s_value,
//   s_new_value and s_index. The result channel (m_valid/m_ready) carries
//   m_status, m_count and m_read_value, one result per request, in order.
//   One request is worked on at a time. The list memory has a single read
//   port with registered data, so every entry visited takes a read state and
//   a step state. A refused request, an append, an unused code, or a delete
//   or replace on an empty list walks no entries and a read visits one; an
//   insert at front, a delete and a replace walk every live entry, and an
//   insert at front then writes the front entry in a state of its own.
//   A result sits in an output register; the next request is taken while
//   it waits, and its own result is held back until the receiver takes the
//   earlier one. A stalled receiver therefore stops the block only after
//   one further request.
//   Reset (aresetn, synchronous, active low) empties the list and drops any
//   pending result. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_value_list
    import bvl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [VAL_W-1:0]    s_value,
    input  logic [VAL_W-1:0]    s_new_value,
    input  logic [INDEX_W-1:0]  s_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [CNT_W-1:0]    m_count,
    output logic [VAL_W-1:0]    m_read_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bvl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bvl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_new_value  (s_new_value),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_read_value (m_read_value)
    );

endmodule

// ----- bench/bounded_value_list_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_value_list_check: request/result checker for the bounded value list
// Watches both handshakes. It keeps its own copy of the list and its length,
// works out the result of every accepted request, and compares each
// delivered result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bounded_value_list_check
    import bvl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [VAL_W-1:0]    s_value,
    input  logic [VAL_W-1:0]    s_new_value,
    input  logic [INDEX_W-1:0]  s_index,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [CNT_W-1:0]    m_count,
    input  logic [VAL_W-1:0]    m_read_value,
    output int                  mismatches,
    output int                  outstanding,
    output int                  results_checked,
    output int                  full_refusals
);

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] read_value;
    } list_result_t;

    logic [VAL_W-1:0] list_mem [DEPTH];
    int               list_len;
    list_result_t     pending_results [$];
    int               n_bad;
    int               n_checked;
    int               n_full;

    function automatic list_result_t apply_list_op(
        logic [OP_W-1:0]    op,
        logic [VAL_W-1:0]   value,
        logic [VAL_W-1:0]   new_value,
        logic [INDEX_W-1:0] index
    );
        list_result_t res;
        int           kept;
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            OP_INSERT, OP_APPEND: begin
                // A zero value is refused before fullness is looked at.
                if (value == '0) begin
                    res.status = ST_ZERO;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (op == OP_INSERT) begin
                        for (int i = list_len; i > 0; i--) begin
                            list_mem[i] = list_mem[i-1];
                        end
                        list_mem[0] = value;
                    end else begin
                        list_mem[list_len] = value;
                    end
                    list_len++;
                end
            end
            OP_DELETE: begin
                kept = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] != value) begin
                        list_mem[kept] = list_mem[i];
                        kept++;
                    end
                end
                list_len = kept;
            end
            OP_REPLACE: begin
                if (new_value == '0) begin
                    res.status = ST_ZERO;
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        if (list_mem[i] == value) begin
                            list_mem[i] = new_value;
                        end
                    end
                end
            end
            OP_READ: begin
                if (index >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_mem[index];
                end
            end
            default: begin
                // Unused codes leave everything as it is.
            end
        endcase
        res.count = list_len[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                want = apply_list_op(s_operation, s_value, s_new_value, s_index);
                if (want.status == ST_FULL) begin
                    n_full++;
                end
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result delivered with no request waiting: status %0d count %0d",
                           m_status, m_count);
                    n_bad++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        n_bad++;
                    end
                    if (m_count !== want.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, m_count);
                        n_bad++;
                    end
                    if (m_read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0h, actual %0h",
                               want.read_value, m_read_value);
                        n_bad++;
                    end
                end
            end
        end
        // Published through nonblocking updates so the stimulus side never
        // races the bookkeeping at the same edge.
        mismatches      <= n_bad;
        outstanding     <= pending_results.size();
        results_checked <= n_checked;
        full_refusals   <= n_full;
    end

endmodule

// ----- bench/bounded_value_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_value_list_tb: top level of the bounded value list testbench
// Drives a directed set of requests covering refusals, a full list, multiple
// matches and out-of-range reads, then biased random traffic with random
// gaps on both channels, two long receiver holds and a full drain pause. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module bounded_value_list_tb;
    import bvl_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED_LO   = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNUSED_HI   = 3'd7;
    localparam logic [VAL_W-1:0] MAX_VALUE      = {VAL_W{1'b1}};
    localparam int               RANDOM_REQS    = 1900;
    localparam int               BURST_REQS     = 6;
    localparam int               RX_HOLD_CYCLES = 150;
    localparam int               DRAIN_LIMIT    = 5000;
    localparam int               TAIL_CYCLES    = 2 * DEPTH + 8;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [VAL_W-1:0]    s_value;
    logic [VAL_W-1:0]    s_new_value;
    logic [INDEX_W-1:0]  s_index;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [CNT_W-1:0]    m_count;
    logic [VAL_W-1:0]    m_read_value;

    int   mismatches;
    int   outstanding;
    int   results_checked;
    int   full_refusals;
    int   requests_sent;
    int   rx_hold_reqs;

    bounded_value_list i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_value      (s_value),
        .s_new_value  (s_new_value),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_read_value (m_read_value)
    );

    bounded_value_list_check i_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .s_new_value     (s_new_value),
        .s_index         (s_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_count         (m_count),
        .m_read_value    (m_read_value),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_refusals   (full_refusals)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Small values dominate so that deletes and replaces find matches.
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return '0;
        end else if (r < 8) begin
            return MAX_VALUE;
        end else if (r < 18) begin
            return VAL_W'($urandom);
        end
        return VAL_W'($urandom_range(1, 6));
    endfunction

    // Receiver: runs of ready with random stalls, plus a long hold each time one is requested.
    initial begin
        int run_left;
        int stall_left;
        int holds_taken;
        m_ready     <= 1'b0;
        run_left    = 0;
        stall_left  = 0;
        holds_taken = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (holds_taken != rx_hold_reqs) begin
                m_ready <= 1'b0;
                holds_taken++;
                stall_left = RX_HOLD_CYCLES - 1;
            end else begin
                m_ready <= 1'b1;
                if (run_left == 0) begin
                    stall_left = pick_gap();
                    run_left   = $urandom_range(1, 40);
                end else begin
                    run_left--;
                end
            end
        end
    end

    task automatic send_request(
        logic [OP_W-1:0]    op,
        logic [VAL_W-1:0]   value,
        logic [VAL_W-1:0]   new_value,
        logic [INDEX_W-1:0] index
    );
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= value;
        s_new_value <= new_value;
        s_index     <= index;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic issue(
        logic [OP_W-1:0]    op,
        logic [VAL_W-1:0]   value,
        logic [VAL_W-1:0]   new_value,
        logic [INDEX_W-1:0] index
    );
        int gap;
        send_request(op, value, new_value, index);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic random_request(int fill_bias, bit back_to_back);
        logic [OP_W-1:0] op;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else if (r < 3 + fill_bias) begin
            op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = OP_DELETE;
                1:       op = OP_REPLACE;
                default: op = OP_READ;
            endcase
        end
        if (back_to_back) begin
            send_request(op, pick_value(), pick_value(), INDEX_W'($urandom));
        end else begin
            issue(op, pick_value(), pick_value(), INDEX_W'($urandom));
        end
    endtask

    // Stop offering requests until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        int  fill_bias;
        int  waited;
        bit  drained;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_INSERT;
        s_value       <= '0;
        s_new_value   <= '0;
        s_index       <= '0;
        rx_hold_reqs  = 0;
        requests_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty list: range read, no-match delete and replace, zero refusal.
        issue(OP_READ,    '0, '0, '0);
        issue(OP_DELETE,  31'd5, '0, '0);
        issue(OP_REPLACE, 31'd5, 31'd6, '0);
        issue(OP_INSERT,  '0, '0, '0);
        // Fill to DEPTH with repeated 3s mixed in.
        issue(OP_INSERT,  MAX_VALUE, '0, '0);
        issue(OP_APPEND,  31'd1, '0, '0);
        issue(OP_INSERT,  31'd3, '0, '0);
        issue(OP_APPEND,  31'd3, '0, '0);
        issue(OP_INSERT,  31'd3, '0, '0);
        issue(OP_APPEND,  31'd2, '0, '0);
        issue(OP_APPEND,  31'd3, '0, '0);
        issue(OP_APPEND,  31'd4, '0, '0);
        // Full list: both inserts refused, zero still reported as zero.
        issue(OP_INSERT,  31'd9, '0, '0);
        issue(OP_APPEND,  31'd9, '0, '0);
        issue(OP_APPEND,  '0, '0, '0);
        issue(OP_READ,    '0, '0, 3'd7);
        issue(OP_READ,    '0, '0, 3'd0);
        issue(OP_REPLACE, 31'd3, '0, '0);
        issue(OP_REPLACE, '0, 31'd5, '0);
        issue(OP_REPLACE, 31'd3, 31'd7, '0);
        issue(OP_DELETE,  31'd7, '0, '0);
        issue(OP_DELETE,  '0, '0, '0);
        issue(OP_UNUSED_LO, 31'd8, 31'd8, 3'd1);
        issue(OP_UNUSED_HI, MAX_VALUE, MAX_VALUE, 3'd7);
        issue(OP_READ,    '0, '0, 3'd6);

        fill_bias = 50;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       fill_bias = 30;
                    1:       fill_bias = 55;
                    default: fill_bias = 75;
                endcase
            end
            if (n == 600 || n == 1500) begin
                // Receiver stalls long while requests keep coming.
                rx_hold_reqs++;
                repeat (BURST_REQS) random_request(fill_bias, 1'b1);
            end
            if (n == 1100) begin
                drain_results();
            end
            random_request(fill_bias, 1'b0);
        end

        s_valid <= 1'b0;
        waited  = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge aclk);
        drained = (outstanding == 0);
        if (!drained) begin
            $error("%0d results never arrived", outstanding);
        end

        $display("Sent %0d requests over all five operations and unused codes;",
                 requests_sent);
        $display("checked %0d results, %0d of them full-list refusals.",
                 results_checked, full_refusals);
        if (drained && mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bvl_pkg.sv
src/bvl_datapath.sv
src/bvl_ctrl.sv
src/bounded_value_list.sv
bench/bounded_value_list_check.sv
bench/bounded_value_list_tb.sv
